### hw/rtl/i2cbb_pkg.sv
package i2cbb_pkg;

    // Port field widths
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 7;
    localparam int CNT_W   = 6;
    localparam int SLOT_W  = 5;
    localparam int BYTE_W  = 8;

    // Byte position and write counter width: a count plus the address byte
    localparam int POS_W   = CNT_W + 1;
    localparam int WAIT_W  = 3;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_START = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Half-bit sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_START2  = 4'd2,
        PH_ADDR    = 4'd3,
        PH_DATA    = 4'd4,
        PH_WBIT    = 4'd5,
        PH_READ    = 4'd6,
        PH_RBIT    = 4'd7,
        PH_RACK    = 4'd8,
        PH_WACK    = 4'd9,
        PH_WAIT    = 4'd10,
        PH_STOP    = 4'd11,
        PH_STOP2   = 4'd12,
        PH_RESTART = 4'd13,
        PH_STOP3   = 4'd14
    } phase_t;

    localparam logic [BYTE_W-1:0] MSB_MASK  = 8'h80;
    localparam logic [WAIT_W-1:0] ACK_WAIT  = 3'd4;
    localparam logic [WAIT_W-1:0] READ_WAIT = 3'd2;

endpackage

### hw/rtl/i2c_bitbang_master.sv
// Tick-driven I2C master for one bus. Every accepted item gives exactly one
// result item, and the block takes one item per clock cycle: the sequencer
// state is updated at acceptance and the result is registered along with it,
// so in_ready only drops while that register holds a result
// that is not yet taken. A load item stores a write byte in the buffer (only
// while idle), a start item latches the address and byte counts (only while
// idle), and each tick item advances SCL/SDA by one half-bit, sampling
// sda_in where the slave drives the line. Read bytes are stored back into
// the buffer at the slot of their byte number and reported on the tick that
// completes them. The buffer is a RAM with a registered read port; its read
// address follows the byte position, which stays put through the ACK and
// wait phases before a data byte is fetched, so no tick waits on the memory.
module i2c_bitbang_master #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [i2cbb_pkg::FUNC_W-1:0]  func,
    input  logic                          sda_in,
    input  logic [i2cbb_pkg::ADDR_W-1:0]  dev_address,
    input  logic [i2cbb_pkg::CNT_W-1:0]   write_count,
    input  logic [i2cbb_pkg::CNT_W-1:0]   read_count,
    input  logic [i2cbb_pkg::SLOT_W-1:0]  byte_index,
    input  logic [i2cbb_pkg::BYTE_W-1:0]  byte_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          scl_out,
    output logic                          sda_out,
    output logic                          sda_drive,
    output logic                          busy_res,
    output logic                          done_res,
    output logic                          nack_flag,
    output logic                          read_valid,
    output logic [i2cbb_pkg::SLOT_W-1:0]  read_index,
    output logic [i2cbb_pkg::BYTE_W-1:0]  read_byte
);

    import i2cbb_pkg::*;

    localparam int IDX_W = $clog2(BUF_DEPTH);
    localparam int EXT_W = POS_W + IDX_W + SLOT_W;

    // Sequencer state
    phase_t              phase_reg, phase_next;
    logic                cp_reg, cp_next;
    logic                nack_reg, nack_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [BYTE_W-1:0]   mask_reg, mask_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    wleft_reg, wleft_next;
    logic [CNT_W-1:0]    rleft_reg, rleft_next;
    logic                restart_reg, restart_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic [ADDR_W-1:0]   taddr_reg, taddr_next;
    logic                scl_reg, scl_next;
    logic                sdal_reg, sdal_next;
    logic                sdae_reg, sdae_next;

    // Result register
    logic                ovalid_reg;
    logic                scl_out_reg, sda_out_reg, sda_drive_reg, busy_reg;
    logic                done_reg, nackf_reg, rvalid_reg;
    logic [SLOT_W-1:0]   rindex_reg;
    logic [BYTE_W-1:0]   rbyte_reg;

    // Per-item results
    logic                done_w, rvalid_w;
    logic [SLOT_W-1:0]   rindex_w;
    logic [BYTE_W-1:0]   rbyte_w;

    // Buffer RAM
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

    logic                in_fire;
    logic [EXT_W-1:0]    slot_ext;
    logic                idx_ok;
    logic [CNT_W-1:0]    wcount_clamp, rcount_clamp;

    assign in_ready = !ovalid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Slot of the current byte: byte numbers count from one
    assign slot_ext  = EXT_W'(pos_reg - POS_W'(1));
    assign ram_raddr = slot_ext[IDX_W-1:0];

    assign idx_ok       = EXT_W'(byte_index) < EXT_W'(BUF_DEPTH);
    assign wcount_clamp = (EXT_W'(write_count) > EXT_W'(BUF_DEPTH)) ?
                          CNT_W'(BUF_DEPTH) : write_count;
    assign rcount_clamp = (EXT_W'(read_count) > EXT_W'(BUF_DEPTH)) ?
                          CNT_W'(BUF_DEPTH) : read_count;

    i2cbb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state and per-item results
    always_comb
    begin
        phase_next   = phase_reg;
        cp_next      = cp_reg;
        nack_next    = nack_reg;
        shift_next   = shift_reg;
        mask_next    = mask_reg;
        pos_next     = pos_reg;
        wleft_next   = wleft_reg;
        rleft_next   = rleft_reg;
        restart_next = restart_reg;
        wait_next    = wait_reg;
        taddr_next   = taddr_reg;
        scl_next     = scl_reg;
        sdal_next    = sdal_reg;
        sdae_next    = sdae_reg;
        done_w       = 1'b0;
        rvalid_w     = 1'b0;
        rindex_w     = '0;
        rbyte_w      = '0;
        ram_we       = 1'b0;
        ram_waddr    = slot_ext[IDX_W-1:0];
        ram_wdata    = shift_reg;

        if (in_fire)
        begin
            case (func_t'(func))
                FUNC_LOAD:
                begin
                    if (phase_reg == PH_IDLE && idx_ok)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(EXT_W'(byte_index));
                        ram_wdata = byte_value;
                    end
                end
                FUNC_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        taddr_next = dev_address;
                        wleft_next = POS_W'(wcount_clamp);
                        rleft_next = rcount_clamp;
                        nack_next  = 1'b0;
                        cp_next    = 1'b1;
                        phase_next = PH_START;
                    end
                end
                FUNC_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        scl_next = cp_reg;
                        case (phase_reg)
                            PH_START:
                            begin
                                phase_next = PH_START2;
                            end
                            PH_START2:
                            begin
                                sdal_next  = 1'b0;
                                sdae_next  = 1'b1;
                                cp_next    = 1'b0;
                                nack_next  = 1'b0;
                                phase_next = PH_ADDR;
                            end
                            PH_ADDR, PH_DATA, PH_WBIT:
                            begin
                                // load the byte to send on the first half-bit
                                if (phase_reg == PH_ADDR)
                                begin
                                    shift_next = {taddr_reg, 1'b0};
                                    if (wleft_reg != '0)
                                    begin
                                        restart_next = 1'b0;
                                    end
                                    else
                                    begin
                                        shift_next[0] = 1'b1;
                                        restart_next  = 1'b1;
                                    end
                                    pos_next   = '0;
                                    wleft_next = wleft_reg + POS_W'(1);
                                end
                                else if (phase_reg == PH_DATA)
                                begin
                                    shift_next = ram_rdata;
                                end
                                if (phase_reg != PH_WBIT)
                                begin
                                    phase_next = PH_WBIT;
                                    mask_next  = MSB_MASK;
                                    sdae_next  = 1'b1;
                                end
                                // SCL low: put the next bit on SDA
                                if (!cp_reg)
                                begin
                                    sdal_next = |(shift_next & mask_next);
                                    mask_next = mask_next >> 1;
                                end
                                // last bit clocked out: go check ACK
                                if (mask_next == '0 && cp_reg)
                                begin
                                    pos_next = pos_next + POS_W'(1);
                                    if (wleft_next != '0)
                                    begin
                                        wleft_next = wleft_next - POS_W'(1);
                                    end
                                    phase_next = PH_RACK;
                                end
                                cp_next = !cp_reg;
                            end
                            PH_READ, PH_RBIT:
                            begin
                                if (phase_reg == PH_READ)
                                begin
                                    sdae_next  = 1'b0;
                                    phase_next = PH_RBIT;
                                    mask_next  = MSB_MASK;
                                    shift_next = '0;
                                end
                                // SCL high: sample SDA
                                if (cp_reg)
                                begin
                                    if (sda_in)
                                    begin
                                        shift_next = shift_next | mask_next;
                                    end
                                    mask_next = mask_next >> 1;
                                    if (mask_next == '0)
                                    begin
                                        ram_we    = 1'b1;
                                        ram_waddr = slot_ext[IDX_W-1:0];
                                        ram_wdata = shift_next;
                                        rvalid_w  = 1'b1;
                                        rindex_w  = slot_ext[SLOT_W-1:0];
                                        rbyte_w   = shift_next;
                                        pos_next  = pos_reg + POS_W'(1);
                                        if (rleft_reg != '0)
                                        begin
                                            rleft_next = rleft_reg - CNT_W'(1);
                                        end
                                        phase_next = PH_WACK;
                                    end
                                end
                                cp_next = !cp_reg;
                            end
                            PH_RACK:
                            begin
                                if (!cp_reg)
                                begin
                                    sdae_next = 1'b0;
                                end
                                else if (!sda_in)
                                begin
                                    if (wleft_reg != '0 || restart_reg)
                                    begin
                                        wait_next  = ACK_WAIT;
                                        phase_next = PH_WAIT;
                                    end
                                    else
                                    begin
                                        phase_next = PH_STOP;
                                    end
                                end
                                else
                                begin
                                    nack_next  = 1'b1;
                                    phase_next = PH_STOP;
                                end
                                cp_next = !cp_reg;
                            end
                            PH_WACK:
                            begin
                                // ACK while more bytes follow, NACK on the last
                                if (!cp_reg)
                                begin
                                    sdal_next = (rleft_reg == '0);
                                    sdae_next = 1'b1;
                                end
                                else if (rleft_reg != '0)
                                begin
                                    wait_next  = READ_WAIT;
                                    phase_next = PH_WAIT;
                                end
                                else
                                begin
                                    phase_next = PH_STOP;
                                end
                                cp_next = !cp_reg;
                            end
                            PH_WAIT:
                            begin
                                if (wait_reg != '0)
                                begin
                                    wait_next = wait_reg - WAIT_W'(1);
                                end
                                else if (wleft_reg != '0)
                                begin
                                    phase_next = PH_DATA;
                                end
                                else if (rleft_reg != '0)
                                begin
                                    phase_next = PH_READ;
                                end
                                else
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                            PH_STOP:
                            begin
                                sdal_next = 1'b0;
                                sdae_next = 1'b1;
                                if (cp_reg)
                                begin
                                    phase_next = PH_STOP2;
                                end
                                cp_next = 1'b1;
                            end
                            PH_STOP2:
                            begin
                                // reads pending after the write phase: restart
                                if (nack_reg || rleft_reg == '0)
                                begin
                                    phase_next = PH_STOP3;
                                end
                                else
                                begin
                                    sdal_next = 1'b1;
                                    sdae_next = 1'b1;
                                    cp_next   = !cp_reg;
                                    if (!cp_reg)
                                    begin
                                        phase_next   = PH_RESTART;
                                        restart_next = 1'b1;
                                    end
                                end
                            end
                            PH_RESTART:
                            begin
                                phase_next = PH_START2;
                            end
                            PH_STOP3:
                            begin
                                sdae_next  = 1'b0;
                                phase_next = PH_IDLE;
                                done_w     = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                done_w     = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cp_reg      <= 1'b1;
            nack_reg    <= 1'b0;
            shift_reg   <= '0;
            mask_reg    <= '0;
            pos_reg     <= '0;
            wleft_reg   <= '0;
            rleft_reg   <= '0;
            restart_reg <= 1'b0;
            wait_reg    <= '0;
            taddr_reg   <= '0;
            scl_reg     <= 1'b1;
            sdal_reg    <= 1'b1;
            sdae_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            cp_reg      <= cp_next;
            nack_reg    <= nack_next;
            shift_reg   <= shift_next;
            mask_reg    <= mask_next;
            pos_reg     <= pos_next;
            wleft_reg   <= wleft_next;
            rleft_reg   <= rleft_next;
            restart_reg <= restart_next;
            wait_reg    <= wait_next;
            taddr_reg   <= taddr_next;
            scl_reg     <= scl_next;
            sdal_reg    <= sdal_next;
            sdae_reg    <= sdae_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ovalid_reg <= in_valid;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scl_out_reg   <= scl_next;
            sda_out_reg   <= sdae_next ? sdal_next : 1'b1;
            sda_drive_reg <= sdae_next;
            busy_reg      <= (phase_next != PH_IDLE);
            done_reg      <= done_w;
            nackf_reg     <= nack_next;
            rvalid_reg    <= rvalid_w;
            rindex_reg    <= rindex_w;
            rbyte_reg     <= rbyte_w;
        end
    end

    assign out_valid  = ovalid_reg;
    assign scl_out    = scl_out_reg;
    assign sda_out    = sda_out_reg;
    assign sda_drive  = sda_drive_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign nack_flag  = nackf_reg;
    assign read_valid = rvalid_reg;
    assign read_index = rindex_reg;
    assign read_byte  = rbyte_reg;

`ifndef NO_ASSERTIONS
    // bit mask walks a single bit or is empty
    a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(mask_reg))
        else $error("bit mask has more than one bit set");

    // an idle bus is released
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !sdae_reg)
        else $error("SDA driven while idle");

    // a captured byte is reported mid-transfer
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> busy_res && !done_res)
        else $error("read byte reported outside a transfer");

    // completion leaves the bus idle and released
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !sda_drive && sda_out)
        else $error("transfer done with bus not released");
`endif

endmodule

### hw/rtl/i2cbb_ram.sv
module i2cbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### bench/testbench.sv
module testbench;

    import i2cbb_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int SLOTS        = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 4;

    // One item offered to the master
    typedef struct packed {
        func_t      kind;
        logic       sda;
        logic [6:0] addr;
        logic [5:0] wcnt;
        logic [5:0] rcnt;
        logic [4:0] idx;
        logic [7:0] val;
    } bus_item_t;

    // Line levels and status returned for one item
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       done;
        logic       nack;
        logic       rvalid;
        logic [4:0] rindex;
        logic [7:0] rbyte;
    } bus_view_t;

    typedef struct packed {
        bus_item_t it;
        logic      typed;
        bus_view_t want;
    } dir_row_t;

    localparam bus_view_t VIEW_IDLE = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0};
    localparam bus_view_t VIEW_BUSY = {1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0};
    localparam bus_view_t VIEW_SDA_LOW = {1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 5'd0, 8'd0};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] func;
    logic       sda_in;
    logic [6:0] dev_address;
    logic [5:0] write_count;
    logic [5:0] read_count;
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic       out_valid;
    logic       out_ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       nack_flag;
    logic       read_valid;
    logic [4:0] read_index;
    logic [7:0] read_byte;

    bus_view_t bus_view_q[$];
    dir_row_t  dir_rows[$];
    int        fault_count  = 0;
    int        results_seen = 0;
    int        idle_mode    = 0;

    // Predicted master state
    phase_t     cur_phase    = PH_IDLE;
    logic       half_clk     = 1'b1;
    logic       nack_latched = 1'b0;
    logic [7:0] shreg        = '0;
    logic [7:0] bitsel       = '0;
    int         pos          = 0;
    int         wr_left      = 0;
    int         rd_left      = 0;
    logic       restarted    = 1'b0;
    int         wait_cnt     = 0;
    logic [6:0] addr_lat     = '0;
    logic [7:0] byte_mem[SLOTS];
    logic       scl_q        = 1'b1;
    logic       sda_q        = 1'b1;
    logic       sda_en       = 1'b0;

    i2c_bitbang_master i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .sda_in      (sda_in),
        .dev_address (dev_address),
        .write_count (write_count),
        .read_count  (read_count),
        .byte_index  (byte_index),
        .byte_value  (byte_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .scl_out     (scl_out),
        .sda_out     (sda_out),
        .sda_drive   (sda_drive),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .nack_flag   (nack_flag),
        .read_valid  (read_valid),
        .read_index  (read_index),
        .read_byte   (read_byte)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int clamp_count(input logic [5:0] v);
        return (v > SLOTS) ? SLOTS : int'(v);
    endfunction

    // Advance the half-bit sequencer by one item and return the bus view
    function automatic bus_view_t advance_bus(input bus_item_t it);
        bus_view_t  r;
        logic [4:0] slot;
        r = '0;
        case (it.kind)
            FUNC_LOAD:
            begin
                if (cur_phase == PH_IDLE)
                    byte_mem[it.idx] = it.val;
            end
            FUNC_START:
            begin
                if (cur_phase == PH_IDLE)
                begin
                    addr_lat     = it.addr;
                    wr_left      = clamp_count(it.wcnt);
                    rd_left      = clamp_count(it.rcnt);
                    nack_latched = 1'b0;
                    half_clk     = 1'b1;
                    cur_phase    = PH_START;
                end
            end
            FUNC_TICK:
            begin
                if (cur_phase != PH_IDLE)
                begin
                    scl_q = half_clk;
                    case (cur_phase)
                        PH_START:
                            cur_phase = PH_START2;
                        PH_START2:
                        begin
                            sda_q        = 1'b0;
                            sda_en       = 1'b1;
                            half_clk     = 1'b0;
                            nack_latched = 1'b0;
                            cur_phase    = PH_ADDR;
                        end
                        PH_ADDR, PH_DATA, PH_WBIT:
                        begin
                            // address byte: R/W set when there is nothing to write
                            if (cur_phase == PH_ADDR)
                            begin
                                shreg = {addr_lat, 1'b0};
                                if (wr_left != 0)
                                    restarted = 1'b0;
                                else
                                begin
                                    shreg[0]  = 1'b1;
                                    restarted = 1'b1;
                                end
                                pos = 0;
                                wr_left++;
                            end
                            else if (cur_phase == PH_DATA)
                                shreg = byte_mem[5'(pos - 1)];
                            if (cur_phase != PH_WBIT)
                            begin
                                cur_phase = PH_WBIT;
                                bitsel    = 8'h80;
                                sda_en    = 1'b1;
                            end
                            if (!half_clk)
                            begin
                                sda_q  = |(shreg & bitsel);
                                bitsel = bitsel >> 1;
                            end
                            if (bitsel == 0 && half_clk)
                            begin
                                pos++;
                                if (wr_left != 0)
                                    wr_left--;
                                cur_phase = PH_RACK;
                            end
                            half_clk = ~half_clk;
                        end
                        PH_READ, PH_RBIT:
                        begin
                            if (cur_phase == PH_READ)
                            begin
                                sda_en    = 1'b0;
                                cur_phase = PH_RBIT;
                                bitsel    = 8'h80;
                                shreg     = '0;
                            end
                            // sample on the high half, MSB first
                            if (half_clk)
                            begin
                                if (it.sda)
                                    shreg = shreg | bitsel;
                                bitsel = bitsel >> 1;
                                if (bitsel == 0)
                                begin
                                    slot           = 5'(pos - 1);
                                    byte_mem[slot] = shreg;
                                    r.rvalid       = 1'b1;
                                    r.rindex       = slot;
                                    r.rbyte        = shreg;
                                    pos++;
                                    if (rd_left != 0)
                                        rd_left--;
                                    cur_phase = PH_WACK;
                                end
                            end
                            half_clk = ~half_clk;
                        end
                        PH_RACK:
                        begin
                            if (!half_clk)
                                sda_en = 1'b0;
                            else if (!it.sda)
                            begin
                                if (wr_left != 0 || restarted)
                                begin
                                    wait_cnt  = 4;
                                    cur_phase = PH_WAIT;
                                end
                                else
                                    cur_phase = PH_STOP;
                            end
                            else
                            begin
                                nack_latched = 1'b1;
                                cur_phase    = PH_STOP;
                            end
                            half_clk = ~half_clk;
                        end
                        PH_WACK:
                        begin
                            // ACK all but the last read byte
                            if (!half_clk)
                            begin
                                sda_q  = (rd_left == 0);
                                sda_en = 1'b1;
                            end
                            else if (rd_left != 0)
                            begin
                                wait_cnt  = 2;
                                cur_phase = PH_WAIT;
                            end
                            else
                                cur_phase = PH_STOP;
                            half_clk = ~half_clk;
                        end
                        PH_WAIT:
                        begin
                            if (wait_cnt != 0)
                                wait_cnt--;
                            else if (wr_left != 0)
                                cur_phase = PH_DATA;
                            else if (rd_left != 0)
                                cur_phase = PH_READ;
                            else
                                cur_phase = PH_STOP;
                        end
                        PH_STOP:
                        begin
                            sda_q  = 1'b0;
                            sda_en = 1'b1;
                            if (half_clk)
                                cur_phase = PH_STOP2;
                            half_clk = 1'b1;
                        end
                        PH_STOP2:
                        begin
                            // reads still owed after a write phase: restart
                            if (nack_latched || rd_left == 0)
                                cur_phase = PH_STOP3;
                            else
                            begin
                                sda_q    = 1'b1;
                                sda_en   = 1'b1;
                                half_clk = ~half_clk;
                                if (half_clk)
                                begin
                                    cur_phase = PH_RESTART;
                                    restarted = 1'b1;
                                end
                            end
                        end
                        PH_RESTART:
                            cur_phase = PH_START2;
                        PH_STOP3:
                        begin
                            sda_en    = 1'b0;
                            cur_phase = PH_IDLE;
                            r.done    = 1'b1;
                        end
                        default:
                        begin
                            cur_phase = PH_IDLE;
                            r.done    = 1'b1;
                        end
                    endcase
                end
            end
            default:
                ;
        endcase
        r.scl   = scl_q;
        r.sda   = sda_en ? sda_q : 1'b1;
        r.drive = sda_en;
        r.busy  = (cur_phase != PH_IDLE);
        r.nack  = nack_latched;
        return r;
    endfunction

    task automatic add_row(input func_t k, input logic s, input logic [6:0] a,
                           input logic [5:0] w, input logic [5:0] rc, input logic [4:0] i,
                           input logic [7:0] v, input logic typed, input bus_view_t want);
        dir_row_t row;
        row.it    = {k, s, a, w, rc, i, v};
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offer one item, wait for it to be taken, then log its expected view
    task automatic issue_item(input bus_item_t it, input logic typed, input bus_view_t want);
        bus_view_t predicted;
        int        gap_pct;
        in_valid    <= 1'b1;
        func        <= it.kind;
        sda_in      <= it.sda;
        dev_address <= it.addr;
        write_count <= it.wcnt;
        read_count  <= it.rcnt;
        byte_index  <= it.idx;
        byte_value  <= it.val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_bus(it);
        bus_view_q.push_back(typed ? want : predicted);
        // sender gaps
        gap_pct = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 33 : 0;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
    endtask

    // Tick whose SDA plays a slave: ACK mostly, NACK at the given rate
    function automatic bus_item_t make_tick(input int nack_pct);
        bus_item_t it;
        it      = bus_item_t'({$urandom, $urandom});
        it.kind = FUNC_TICK;
        if (cur_phase == PH_RACK && half_clk)
            it.sda = ($urandom_range(99) < nack_pct);
        return it;
    endfunction

    // Byte counts: mostly short, a few past the buffer depth
    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 6'($urandom_range(3, 0));
        else if (r < 92)
            return 6'($urandom_range(8, 4));
        return 6'($urandom_range(63, 9));
    endfunction

    task automatic run_random();
        bus_item_t it;
        int        counted;
        int        nack_pct;
        int        r;
        counted  = 0;
        nack_pct = 8;
        // let the directed transfer finish, then fill every slot
        while (cur_phase != PH_IDLE)
            issue_item(make_tick(nack_pct), 1'b0, '0);
        for (int s = 0; s < SLOTS; s++)
        begin
            it      = bus_item_t'({$urandom, $urandom});
            it.kind = FUNC_LOAD;
            it.idx  = 5'(s);
            issue_item(it, 1'b0, '0);
        end
        while (counted < RANDOM_ITEMS || cur_phase != PH_IDLE)
        begin
            idle_mode = (counted / 150) % 4;
            it        = bus_item_t'({$urandom, $urandom});
            if (cur_phase != PH_IDLE)
            begin
                if ($urandom_range(99) < 4)
                    it.kind = func_t'($urandom_range(3, 1));
                else
                begin
                    it = make_tick(nack_pct);
                    counted++;
                end
            end
            else
            begin
                counted++;
                r = $urandom_range(99);
                if (r < 45)
                begin
                    it.kind  = FUNC_START;
                    it.wcnt  = pick_count();
                    it.rcnt  = pick_count();
                    nack_pct = (it.wcnt > 8 || it.rcnt > 8) ? 50 : 8;
                end
                else if (r < 75)
                    it.kind = FUNC_LOAD;
                else if (r < 88)
                    it.kind = FUNC_NOP;
                else
                    it.kind = FUNC_TICK;
            end
            issue_item(it, 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            fault_count++;
            $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic compare_view(input bus_view_t want, input bus_view_t got);
        check_field("scl_out", 8'(want.scl), 8'(got.scl));
        check_field("sda_out", 8'(want.sda), 8'(got.sda));
        check_field("sda_drive", 8'(want.drive), 8'(got.drive));
        check_field("busy_res", 8'(want.busy), 8'(got.busy));
        check_field("done_res", 8'(want.done), 8'(got.done));
        check_field("nack_flag", 8'(want.nack), 8'(got.nack));
        check_field("read_valid", 8'(want.rvalid), 8'(got.rvalid));
        check_field("read_index", 8'(want.rindex), 8'(got.rindex));
        check_field("read_byte", want.rbyte, got.rbyte);
    endtask

    // Stimulus: reset, directed rows, random transfers, drain
    initial
    begin : stimulus
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_NOP;
        sda_in      <= 1'b1;
        dev_address <= '0;
        write_count <= '0;
        read_count  <= '0;
        byte_index  <= '0;
        byte_value  <= '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // idle: nothing moves the bus
        add_row(FUNC_NOP, 1'b1, 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_IDLE);
        add_row(FUNC_TICK, 1'b0, 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_IDLE);
        add_row(FUNC_TICK, 1'b1, 7'h7f, 6'd63, 6'd63, 5'd31, 8'hff, 1'b1, VIEW_IDLE);
        add_row(FUNC_LOAD, 1'b0, 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_IDLE);
        add_row(FUNC_LOAD, 1'b1, 7'h7f, 6'd63, 6'd63, 5'd31, 8'hff, 1'b1, VIEW_IDLE);
        add_row(FUNC_LOAD, 1'b0, 7'h00, 6'd0, 6'd0, 5'd10, 8'ha5, 1'b1, VIEW_IDLE);
        // nothing-to-transfer start at the top address
        add_row(FUNC_START, 1'b0, 7'h7f, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_BUSY);
        // load, start and no-op while busy are ignored
        add_row(FUNC_LOAD, 1'b0, 7'h00, 6'd0, 6'd0, 5'd3, 8'h5a, 1'b1, VIEW_BUSY);
        add_row(FUNC_START, 1'b0, 7'h00, 6'd63, 6'd63, 5'd0, 8'h00, 1'b1, VIEW_BUSY);
        add_row(FUNC_NOP, 1'b0, 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_BUSY);
        // start condition: SDA falls while SCL high
        add_row(FUNC_TICK, 1'b1, 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_BUSY);
        add_row(FUNC_TICK, 1'b0, 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b1, VIEW_SDA_LOW);
        // first address bits
        for (int n = 0; n < 10; n++)
            add_row(FUNC_TICK, 1'(n), 7'h00, 6'd0, 6'd0, 5'd0, 8'h00, 1'b0, '0);

        foreach (dir_rows[n])
            issue_item(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].want);

        run_random();
        in_valid <= 1'b0;

        while (bus_view_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fault_count == 0)
            $display("i2c_bitbang_master: match");
        else
            $display("i2c_bitbang_master: mismatch");
        $finish;
    end

    // Result side: random stalls, one long hold-off, checks against the log
    initial
    begin : result_check
        bus_view_t got;
        int        stall_pct;
        int        hold_left;
        logic      hold_done;
        out_ready <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {scl_out, sda_out, sda_drive, busy_res, done_res, nack_flag,
                       read_valid, read_index, read_byte};
                results_seen++;
                if (bus_view_q.size() == 0)
                begin
                    fault_count++;
                    $display("%0t unexpected result: expected none, got %h", $time, got);
                end
                else
                    compare_view(bus_view_q.pop_front(), got);
            end
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            stall_pct = (idle_mode == 2) ? 48 : (idle_mode == 3) ? 33 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: too long without any item moving on either side
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("i2c_bitbang_master: mismatch");
        $finish;
    end

endmodule
